>>> hw/rtl/vdf_pkg.sv
// vdf_pkg: shared widths, types, register indexes and reset values for the
// velocity drag force pipeline.
// No dependencies.
package vdf_pkg;

    localparam int unsigned NUM_AXES       = 3;
    localparam int unsigned VEL_W          = 24;
    localparam int unsigned SUM_W          = 2 * VEL_W;
    localparam int unsigned ROOT_W         = VEL_W;
    localparam int unsigned BITS_PER_STAGE = 2;
    localparam int unsigned SQRT_STAGES    = ROOT_W / BITS_PER_STAGE;
    localparam int unsigned COEFF_W        = 16;
    localparam int unsigned FRAC_W         = 12;
    localparam int unsigned KPROD_W        = COEFF_W + ROOT_W;
    localparam int unsigned SCALE_W        = KPROD_W - FRAC_W + 1;
    localparam int unsigned PROD_W         = SCALE_W + VEL_W;
    localparam int unsigned MAG_W          = PROD_W - COEFF_W;
    localparam int unsigned MIN_DRAG_W     = 23;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 23;

    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_COEFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUADRATIC_COEFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DRAG        = 2'd2;

    localparam logic [COEFF_W-1:0]    LINEAR_COEFF_RST    = 16'd655;
    localparam logic [COEFF_W-1:0]    QUADRATIC_COEFF_RST = 16'd655;
    localparam logic [MIN_DRAG_W-1:0] MIN_DRAG_RST        = 23'd41;

    localparam logic [VEL_W-1:0] SAT_POS     = 24'h7F_FFFF;
    localparam logic [VEL_W-1:0] SAT_NEG_MAG = 24'h80_0000;

    typedef logic [NUM_AXES-1:0][VEL_W-1:0] t_vec;

    typedef struct packed {
        logic [NUM_AXES-1:0] neg;
        t_vec                mag;
    } t_side;

    typedef struct packed {
        logic [COEFF_W-1:0]    linear_coeff;
        logic [COEFF_W-1:0]    quadratic_coeff;
        logic [MIN_DRAG_W-1:0] min_drag;
    } t_cfg;

endpackage

>>> hw/rtl/vdf_square.sv
// vdf_square: magnitudes of the velocity components, their squares and the
// sum of squares, three register stages.
// Depends on vdf_pkg.
module vdf_square (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  vdf_pkg::t_vec             i_vel,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [vdf_pkg::SUM_W-1:0] o_sumsq,
    output vdf_pkg::t_side            o_side
);

    logic [2:0] r_vld;
    logic       en0, en1, en2;

    vdf_pkg::t_side n_side0;
    vdf_pkg::t_side r_side0, r_side1, r_side2;
    logic [vdf_pkg::NUM_AXES-1:0][vdf_pkg::SUM_W-1:0] r_sq;
    logic [vdf_pkg::SUM_W-1:0] r_sum;

    assign en2     = !r_vld[2] || i_ready;
    assign en1     = !r_vld[1] || en2;
    assign en0     = !r_vld[0] || en1;
    assign o_ready = en0;
    assign o_valid = r_vld[2];
    assign o_sumsq = r_sum;
    assign o_side  = r_side2;

    always_comb begin
        for (int a = 0; a < vdf_pkg::NUM_AXES; a++) begin
            n_side0.neg[a] = i_vel[a][vdf_pkg::VEL_W-1];
            n_side0.mag[a] = i_vel[a][vdf_pkg::VEL_W-1] ? (vdf_pkg::VEL_W'(0) - i_vel[a])
                                                        : i_vel[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en0) r_vld[0] <= i_valid;
            if (en1) r_vld[1] <= r_vld[0];
            if (en2) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_valid) begin
            r_side0 <= n_side0;
        end
        if (en1 && r_vld[0]) begin
            r_side1 <= r_side0;
            for (int a = 0; a < vdf_pkg::NUM_AXES; a++) begin
                r_sq[a] <= vdf_pkg::SUM_W'(r_side0.mag[a]) * vdf_pkg::SUM_W'(r_side0.mag[a]);
            end
        end
        if (en2 && r_vld[1]) begin
            r_side2 <= r_side1;
            r_sum   <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

endmodule

>>> hw/rtl/vdf_sqrt.sv
// vdf_sqrt: pipelined digit-by-digit integer square root of the sum of
// squares, two root bits per stage; side data travels alongside.
// Depends on vdf_pkg.
module vdf_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [vdf_pkg::SUM_W-1:0]  i_sumsq,
    input  vdf_pkg::t_side             i_side,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [vdf_pkg::ROOT_W-1:0] o_root,
    output vdf_pkg::t_side             o_side
);

    typedef struct packed {
        logic [vdf_pkg::SUM_W-1:0]  rem;
        logic [vdf_pkg::ROOT_W-1:0] res;
    } t_root;

    function automatic t_root sqrt_step(t_root s, int unsigned bitpos);
        logic [vdf_pkg::SUM_W+1:0] trial;
        t_root                     r;
        trial = ((vdf_pkg::SUM_W + 2)'(s.res) << (bitpos + 1))
              | ((vdf_pkg::SUM_W + 2)'(1) << (2 * bitpos));
        r = s;
        if ({2'b00, s.rem} >= trial) begin
            r.rem = s.rem - vdf_pkg::SUM_W'(trial);
            r.res = s.res | (vdf_pkg::ROOT_W'(1) << bitpos);
        end
        return r;
    endfunction

    logic [vdf_pkg::SQRT_STAGES-1:0] r_vld;
    logic [vdf_pkg::SQRT_STAGES:0]   en;
    t_root          r_st   [vdf_pkg::SQRT_STAGES];
    vdf_pkg::t_side r_side [vdf_pkg::SQRT_STAGES];

    assign en[vdf_pkg::SQRT_STAGES] = i_ready;
    assign o_ready = en[0];
    assign o_valid = r_vld[vdf_pkg::SQRT_STAGES-1];
    assign o_root  = r_st[vdf_pkg::SQRT_STAGES-1].res;
    assign o_side  = r_side[vdf_pkg::SQRT_STAGES-1];

    for (genvar g = 0; g < vdf_pkg::SQRT_STAGES; g++) begin : g_stage
        logic           vld_in;
        t_root          st_in;
        t_root          n_st;
        vdf_pkg::t_side side_in;

        assign en[g] = !r_vld[g] || en[g+1];

        if (g == 0) begin : g_first
            assign vld_in  = i_valid;
            assign st_in   = '{rem: i_sumsq, res: '0};
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[g-1];
            assign st_in   = r_st[g-1];
            assign side_in = r_side[g-1];
        end

        always_comb begin
            n_st = st_in;
            for (int b = 0; b < vdf_pkg::BITS_PER_STAGE; b++) begin
                n_st = sqrt_step(n_st,
                    vdf_pkg::ROOT_W - 1 - g * vdf_pkg::BITS_PER_STAGE - b);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (en[g]) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[g] && vld_in) begin
                r_st[g]   <= n_st;
                r_side[g] <= side_in;
            end
        end
    end

endmodule

>>> hw/rtl/vdf_scale.sv
// vdf_scale: drag coefficient, drag size test and the saturated opposing
// force, four register stages ending in the output register.
// Depends on vdf_pkg.
module vdf_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vdf_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [vdf_pkg::ROOT_W-1:0] i_root,
    input  vdf_pkg::t_side             i_side,
    output logic                       o_valid,
    input  logic                       i_ready,
    output vdf_pkg::t_vec              o_drag,
    output logic                       o_applied
);

    function automatic logic [vdf_pkg::VEL_W-1:0] oppose(
        logic [vdf_pkg::MAG_W-1:0] mag, logic neg);
        logic [vdf_pkg::VEL_W-1:0] lim;
        if (neg) begin
            lim = (mag > vdf_pkg::MAG_W'(vdf_pkg::SAT_POS)) ? vdf_pkg::SAT_POS
                                                          : mag[vdf_pkg::VEL_W-1:0];
            return lim;
        end
        lim = (mag > vdf_pkg::MAG_W'(vdf_pkg::SAT_NEG_MAG)) ? vdf_pkg::SAT_NEG_MAG
                                                           : mag[vdf_pkg::VEL_W-1:0];
        return vdf_pkg::VEL_W'(0) - lim;
    endfunction

    logic [3:0] r_vld;
    logic       en0, en1, en2, en3;

    logic [vdf_pkg::KPROD_W-1:0] r_kprod;
    logic [vdf_pkg::ROOT_W-1:0]  r_m0, r_m1;
    vdf_pkg::t_side              r_side0, r_side1;
    logic [vdf_pkg::SCALE_W-1:0] r_coef;
    logic [vdf_pkg::PROD_W-1:0]  r_dprod;
    logic [vdf_pkg::NUM_AXES-1:0][vdf_pkg::PROD_W-1:0] r_cprod;
    logic [vdf_pkg::NUM_AXES-1:0] r_neg2;
    vdf_pkg::t_vec               r_drag;
    logic                        r_applied;
    logic                        hit;

    assign en3       = !r_vld[3] || i_ready;
    assign en2       = !r_vld[2] || en3;
    assign en1       = !r_vld[1] || en2;
    assign en0       = !r_vld[0] || en1;
    assign o_ready   = en0;
    assign o_valid   = r_vld[3];
    assign o_drag    = r_drag;
    assign o_applied = r_applied;

    assign hit = r_dprod[vdf_pkg::PROD_W-1:vdf_pkg::COEFF_W]
              >= vdf_pkg::MAG_W'(i_cfg.min_drag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en0) r_vld[0] <= i_valid;
            if (en1) r_vld[1] <= r_vld[0];
            if (en2) r_vld[2] <= r_vld[1];
            if (en3) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_valid) begin
            r_kprod <= vdf_pkg::KPROD_W'(i_cfg.quadratic_coeff) * vdf_pkg::KPROD_W'(i_root);
            r_m0    <= i_root;
            r_side0 <= i_side;
        end
        if (en1 && r_vld[0]) begin
            r_coef  <= vdf_pkg::SCALE_W'(i_cfg.linear_coeff)
                     + vdf_pkg::SCALE_W'(r_kprod[vdf_pkg::KPROD_W-1:vdf_pkg::FRAC_W]);
            r_m1    <= r_m0;
            r_side1 <= r_side0;
        end
        if (en2 && r_vld[1]) begin
            r_dprod <= vdf_pkg::PROD_W'(r_coef) * vdf_pkg::PROD_W'(r_m1);
            for (int a = 0; a < vdf_pkg::NUM_AXES; a++) begin
                r_cprod[a] <= vdf_pkg::PROD_W'(r_coef) * vdf_pkg::PROD_W'(r_side1.mag[a]);
            end
            r_neg2 <= r_side1.neg;
        end
        if (en3 && r_vld[2]) begin
            r_applied <= hit;
            for (int a = 0; a < vdf_pkg::NUM_AXES; a++) begin
                r_drag[a] <= hit ? oppose(r_cprod[a][vdf_pkg::PROD_W-1:vdf_pkg::COEFF_W],
                                          r_neg2[a])
                                 : '0;
            end
        end
    end

endmodule

>>> hw/rtl/velocity_drag_force.sv
// velocity_drag_force: top level; configuration registers and the chain of
// square, square-root and scale pipelines.
// Depends on vdf_pkg, vdf_square, vdf_sqrt, vdf_scale.
//
// Takes one signed Q12.12 velocity per cycle while o_ready is high and returns
// the linear-plus-quadratic drag force -(k1 + k2*|v|)*v, each component
// saturated to 24 bits, with o_applied low and a zero vector when the drag
// size falls below min_drag. The pipeline is three stages of squaring and
// summing, twelve stages of square root at two root bits each, and four
// stages of coefficient, products and saturation. Every stage holds its own
// valid bit, so bubbles close up under a stall and o_ready stays high while
// any stage is empty. Write configuration only while no beat is in flight.
module velocity_drag_force (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vdf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vdf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [vdf_pkg::VEL_W-1:0] i_vel_x,
    input  logic signed [vdf_pkg::VEL_W-1:0] i_vel_y,
    input  logic signed [vdf_pkg::VEL_W-1:0] i_vel_z,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [vdf_pkg::VEL_W-1:0] o_drag_x,
    output logic signed [vdf_pkg::VEL_W-1:0] o_drag_y,
    output logic signed [vdf_pkg::VEL_W-1:0] o_drag_z,
    output logic                           o_applied
);

    vdf_pkg::t_cfg r_cfg;
    vdf_pkg::t_vec vel;
    vdf_pkg::t_vec drag;

    logic                        sq_valid, sq_ready;
    logic [vdf_pkg::SUM_W-1:0]   sq_sum;
    vdf_pkg::t_side              sq_side;
    logic                        rt_valid, rt_ready;
    logic [vdf_pkg::ROOT_W-1:0]  rt_root;
    vdf_pkg::t_side              rt_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.linear_coeff    <= vdf_pkg::LINEAR_COEFF_RST;
            r_cfg.quadratic_coeff <= vdf_pkg::QUADRATIC_COEFF_RST;
            r_cfg.min_drag        <= vdf_pkg::MIN_DRAG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vdf_pkg::REG_LINEAR_COEFF:
                    r_cfg.linear_coeff <= i_cfg_data[vdf_pkg::COEFF_W-1:0];
                vdf_pkg::REG_QUADRATIC_COEFF:
                    r_cfg.quadratic_coeff <= i_cfg_data[vdf_pkg::COEFF_W-1:0];
                vdf_pkg::REG_MIN_DRAG:
                    r_cfg.min_drag <= i_cfg_data[vdf_pkg::MIN_DRAG_W-1:0];
                default: ;
            endcase
        end
    end

    assign vel[0] = i_vel_x;
    assign vel[1] = i_vel_y;
    assign vel[2] = i_vel_z;

    vdf_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_vel   (vel),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_sumsq (sq_sum),
        .o_side  (sq_side)
    );

    vdf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .o_ready (sq_ready),
        .i_sumsq (sq_sum),
        .i_side  (sq_side),
        .o_valid (rt_valid),
        .i_ready (rt_ready),
        .o_root  (rt_root),
        .o_side  (rt_side)
    );

    vdf_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (rt_valid),
        .o_ready   (rt_ready),
        .i_root    (rt_root),
        .i_side    (rt_side),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_drag    (drag),
        .o_applied (o_applied)
    );

    assign o_drag_x = drag[0];
    assign o_drag_y = drag[1];
    assign o_drag_z = drag[2];

endmodule

>>> verif/velocity_drag_force_tb.sv
// velocity_drag_force_tb: self-checking bench for the velocity drag force pipeline.
// Drives velocity beats through random stalls, predicts each drag result in place.
// Depends on vdf_pkg and velocity_drag_force.
module velocity_drag_force_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VEL_W      = vdf_pkg::VEL_W;
    localparam int CFG_IDX_W  = vdf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = vdf_pkg::CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic signed [VEL_W-1:0] VEL_MAX = vdf_pkg::SAT_POS;
    localparam logic signed [VEL_W-1:0] VEL_MIN = vdf_pkg::SAT_NEG_MAG;
    localparam int NUM_SETTINGS  = 6;
    localparam int RANDOM_BEATS  = 150;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000;

    typedef struct {
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [VEL_W-1:0] z;
    } t_vel_beat;

    typedef struct {
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [VEL_W-1:0] z;
        logic                    applied;
    } t_drag;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [VEL_W-1:0] vel_x = '0;
    logic signed [VEL_W-1:0] vel_y = '0;
    logic signed [VEL_W-1:0] vel_z = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [VEL_W-1:0] drag_x;
    logic signed [VEL_W-1:0] drag_y;
    logic signed [VEL_W-1:0] drag_z;
    logic                    applied;

    logic          in_taken = 1'b0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            error_count = 0;
    int            stall_cycles = 0;
    vdf_pkg::t_cfg cfg_model;
    t_vel_beat     vel_pending[$];
    t_drag         expected_drag[$];

    velocity_drag_force uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_valid    (in_valid),
        .o_ready    (in_ready),
        .i_vel_x    (vel_x),
        .i_vel_y    (vel_y),
        .i_vel_z    (vel_z),
        .o_valid    (out_valid),
        .i_ready    (out_ready),
        .o_drag_x   (drag_x),
        .o_drag_y   (drag_y),
        .o_drag_z   (drag_z),
        .o_applied  (applied)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 25; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_drag predict_drag(input logic signed [VEL_W-1:0] vx,
                                           input logic signed [VEL_W-1:0] vy,
                                           input logic signed [VEL_W-1:0] vz);
        logic signed [VEL_W-1:0] comp [3];
        logic signed [VEL_W-1:0] pull [3];
        bit                      neg [3];
        longint unsigned         mag [3];
        longint                  signed_val;
        longint                  drag_val;
        longint unsigned         sumsq;
        longint unsigned         speed;
        longint unsigned         coef;
        longint unsigned         size;
        longint unsigned         scaled;
        t_drag                   res;
        comp[0] = vx;
        comp[1] = vy;
        comp[2] = vz;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            signed_val = comp[i];
            neg[i] = signed_val < 0;
            mag[i] = neg[i] ? -signed_val : signed_val;
            sumsq += mag[i] * mag[i];
        end
        speed = int_sqrt(sumsq);
        coef = 64'(cfg_model.linear_coeff)
             + ((64'(cfg_model.quadratic_coeff) * speed) >> vdf_pkg::FRAC_W);
        size = (coef * speed) >> vdf_pkg::COEFF_W;
        res.applied = size >= 64'(cfg_model.min_drag);
        for (int i = 0; i < 3; i++) begin
            scaled = (coef * mag[i]) >> vdf_pkg::COEFF_W;
            if (!res.applied) begin
                drag_val = 0;
            end else if (neg[i]) begin
                drag_val = (scaled > 64'(vdf_pkg::SAT_POS)) ? 64'(vdf_pkg::SAT_POS) : scaled;
            end else begin
                drag_val = (scaled > 64'(vdf_pkg::SAT_NEG_MAG))
                         ? -longint'(vdf_pkg::SAT_NEG_MAG)
                         : -longint'(scaled);
            end
            pull[i] = drag_val[VEL_W-1:0];
        end
        res.x = pull[0];
        res.y = pull[1];
        res.z = pull[2];
        return res;
    endfunction

    function automatic logic signed [VEL_W-1:0] rand_component(input int span);
        int mag;
        mag = int'($urandom & ((32'd1 << span) - 1));
        return VEL_W'($urandom_range(1) ? -mag : mag);
    endfunction

    function automatic logic signed [VEL_W-1:0] corner_component();
        case ($urandom_range(4))
            0: return VEL_MAX;
            1: return VEL_MIN;
            2: return '0;
            3: return VEL_W'(1);
            default: return '1;
        endcase
    endfunction

    function automatic t_vel_beat rand_vel();
        t_vel_beat v;
        int        span;
        case ($urandom_range(3))
            0: begin
                v.x = VEL_W'($urandom);
                v.y = VEL_W'($urandom);
                v.z = VEL_W'($urandom);
            end
            1, 2: begin
                span = $urandom_range(VEL_W - 1);
                v.x = rand_component(span);
                v.y = rand_component(span);
                v.z = rand_component(span);
            end
            default: begin
                v.x = $urandom_range(1) ? corner_component() : VEL_W'($urandom);
                v.y = $urandom_range(1) ? corner_component() : VEL_W'($urandom);
                v.z = $urandom_range(1) ? corner_component() : VEL_W'($urandom);
            end
        endcase
        return v;
    endfunction

    task automatic queue_vel(input logic signed [VEL_W-1:0] x,
                             input logic signed [VEL_W-1:0] y,
                             input logic signed [VEL_W-1:0] z);
        t_vel_beat v;
        v.x = x;
        v.y = y;
        v.z = z;
        vel_pending.push_back(v);
    endtask

    task automatic queue_corners();
        queue_vel(0, 0, 0);
        queue_vel(VEL_MAX, VEL_MAX, VEL_MAX);
        queue_vel(VEL_MIN, VEL_MIN, VEL_MIN);
        queue_vel(VEL_MAX, 0, 0);
        queue_vel(0, VEL_MIN, 0);
        queue_vel(1, -1, 1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            vdf_pkg::REG_LINEAR_COEFF:
                cfg_model.linear_coeff    = data[vdf_pkg::COEFF_W-1:0];
            vdf_pkg::REG_QUADRATIC_COEFF:
                cfg_model.quadratic_coeff = data[vdf_pkg::COEFF_W-1:0];
            vdf_pkg::REG_MIN_DRAG:
                cfg_model.min_drag        = data[vdf_pkg::MIN_DRAG_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_drag_config(input int setting);
        case (setting)
            1: begin
                write_reg(vdf_pkg::REG_LINEAR_COEFF, 0);
                write_reg(vdf_pkg::REG_QUADRATIC_COEFF, 0);
                write_reg(vdf_pkg::REG_MIN_DRAG, 0);
            end
            2: begin
                write_reg(vdf_pkg::REG_LINEAR_COEFF, '1);
                write_reg(vdf_pkg::REG_QUADRATIC_COEFF, '1);
                write_reg(vdf_pkg::REG_MIN_DRAG, '1);
            end
            3: begin
                write_reg(vdf_pkg::REG_LINEAR_COEFF, 23'h00_FFFF);
                write_reg(vdf_pkg::REG_QUADRATIC_COEFF, 0);
                write_reg(vdf_pkg::REG_MIN_DRAG, 0);
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            end
            4: begin
                write_reg(vdf_pkg::REG_LINEAR_COEFF, CFG_DATA_W'($urandom));
                write_reg(vdf_pkg::REG_QUADRATIC_COEFF, CFG_DATA_W'($urandom));
                write_reg(vdf_pkg::REG_MIN_DRAG,
                          CFG_DATA_W'($urandom) >> $urandom_range(CFG_DATA_W - 1));
            end
            default: begin
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
                write_reg(vdf_pkg::REG_LINEAR_COEFF, CFG_DATA_W'($urandom_range(2047)));
                write_reg(vdf_pkg::REG_QUADRATIC_COEFF, CFG_DATA_W'($urandom));
                write_reg(vdf_pkg::REG_MIN_DRAG,
                          CFG_DATA_W'($urandom) >> $urandom_range(CFG_DATA_W - 1));
            end
        endcase
    endtask

    task automatic wait_drained();
        do begin
            @(posedge clk);
        end while (vel_pending.size() != 0 || in_valid || expected_drag.size() != 0);
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(negedge clk) begin : drive_vel
        t_vel_beat beat;
        if (rst_n && (!in_valid || in_taken)) begin
            if (vel_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                beat = vel_pending.pop_front();
                vel_x    <= beat.x;
                vel_y    <= beat.y;
                vel_z    <= beat.z;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= $urandom_range(99) >= recv_idle_pct;
    end

    always @(posedge clk) begin : watch_drag
        t_drag want;
        if (!rst_n) begin
            in_taken     <= 1'b0;
            stall_cycles <= 0;
        end else begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                expected_drag.push_back(predict_drag(vel_x, vel_y, vel_z));
            end
            if (out_valid && out_ready) begin
                if (expected_drag.size() == 0) begin
                    $error("drag beat with no velocity pending: x %0d y %0d z %0d applied %0d",
                           drag_x, drag_y, drag_z, applied);
                    error_count++;
                end else begin
                    want = expected_drag.pop_front();
                    compare_field("drag_x", want.x, drag_x);
                    compare_field("drag_y", want.y, drag_y);
                    compare_field("drag_z", want.z, drag_z);
                    compare_field("applied", want.applied, applied);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("velocity_drag_force_tb: FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        cfg_model.linear_coeff    = vdf_pkg::LINEAR_COEFF_RST;
        cfg_model.quadratic_coeff = vdf_pkg::QUADRATIC_COEFF_RST;
        cfg_model.min_drag        = vdf_pkg::MIN_DRAG_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
            case (setting / 2)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 76;
                end
                1: begin
                    send_idle_pct = 76;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (setting != 0) begin
                set_drag_config(setting);
            end
            queue_corners();
            if (setting == 0) begin
                queue_vel(0, 0, VEL_MAX);
                queue_vel(0, 0, VEL_MIN);
                queue_vel(-1, 0, 0);
                queue_vel(0, 1, 0);
                queue_vel(2048, 0, 0);
                queue_vel(3000, 0, 0);
                queue_vel(0, -4096, 0);
                queue_vel(-4096, 4096, -4096);
                queue_vel(VEL_MIN, VEL_MAX, 0);
                queue_vel(VEL_MAX, VEL_MIN, VEL_MAX);
                queue_vel(VEL_MIN, 0, VEL_MIN);
                queue_vel(-2048, 0, 0);
                queue_vel(0, 0, 12'hFFF);
            end
            for (int n = 0; n < RANDOM_BEATS; n++) begin
                vel_pending.push_back(rand_vel());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("velocity_drag_force_tb: PASS");
        end else begin
            $display("velocity_drag_force_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/vdf_pkg.sv
hw/rtl/vdf_square.sv
hw/rtl/vdf_sqrt.sv
hw/rtl/vdf_scale.sv
hw/rtl/velocity_drag_force.sv
verif/velocity_drag_force_tb.sv
